// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VEE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define VEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VEE_ASSERT_IMP(lbl, ante, cons, msg)
`define VEE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/vee_pkg.sv =====
// Constants and types of the Vreman eddy viscosity unit.
package vee_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_DIFFS      = 9;
    localparam int IN_W           = 352;
    localparam int OUT_W          = 32;
    localparam int FRONT_STAGES   = 10;
    localparam int DIV_STEPS      = 64;
    localparam int SQRT_STEPS     = 32;
    localparam int PIPE_STAGES    = FRONT_STAGES + DIV_STEPS + SQRT_STEPS + 2;

    localparam logic [31:0] NORM_MIN        = 32'd429;
    localparam logic [97:0] BB_THRESHOLD    = 98'd184467440737;
    localparam logic [26:0] EDDY_COEF       = 27'd107374182;
    localparam logic [31:0] INV_SPACING_RST = 32'd4096;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_INV_X  = 3'd1,
        REG_INV_Y  = 3'd2,
        REG_INV_Z  = 3'd3,
        REG_SQ_X   = 3'd4,
        REG_SQ_Y   = 3'd5,
        REG_SQ_Z   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] dens;
        logic [31:0] visc;
        logic        added;
        logic        ovf;
    } side_t;

endpackage

// ===== rtl/core/vreman_eddy_viscosity_unit.sv =====
// Vreman subgrid eddy viscosity unit: fully pipelined fixed-point datapath.
//
//  channel | ports                         | beat contents
//  --------+-------------------------------+---------------------------------------
//  input   | s_tvalid s_tready s_tdata     | nine differences, density, viscosity
//  result  | m_tvalid m_tready m_tdata/user| updated viscosity, eddy flag
//  config  | cfg_valid cfg_ready cfg_index | register index and write data
//
// One beat enters per cycle unless the pipeline holds; a result passes through the
// ten front stages, the 64-stage restoring divider and the 32-stage square root.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The whole pipeline holds while the output register is full and not taken.
`include "assert_macros.svh"
module vreman_eddy_viscosity_unit
    import vee_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // dux_along_x, dux_along_y, dux_along_z, duy_along_x, duy_along_y,
    // duy_along_z, duz_along_x, duz_along_y, duz_along_z, density, viscosity_in
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // viscosity_out
    output logic [OUT_W-1:0] m_tdata,
    // eddy_added
    output logic             m_tuser,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam logic [32:0] VISC_CAP = (DATA_WIDTH >= 32) ? 33'h0FFFFFFFF :
                                       33'((64'd1 << DATA_WIDTH) - 64'd1);
    localparam int SIDE_DIV  = FRONT_STAGES + DIV_STEPS;
    localparam int SIDE_SQRT = SIDE_DIV + SQRT_STEPS;

    // configuration registers
    logic        enable_reg;
    logic [31:0] inv_reg [3];
    logic [31:0] sqs_reg [3];

    logic advance;
    logic [PIPE_STAGES:1] vld_reg, vld_next;
    side_t side_reg [1:PIPE_STAGES];
    side_t side_next [1:PIPE_STAGES];

    logic [63:0] m1_reg [9], m1_next [9];
    logic        n1_reg [9], n1_next [9];
    logic [31:0] gm2_reg [9], gm2_next [9];
    logic        gs2_reg [9], gs2_next [9];
    logic [63:0] sq3_reg [9], sq3_next [9];
    logic [63:0] om3_reg [9], om3_next [9];
    logic        os3_reg [9], os3_next [9];
    logic [65:0] np4_reg [3], np4_next [3];
    logic [63:0] pl4_reg [18], pl4_next [18];
    logic [63:0] ph4_reg [18], ph4_next [18];
    logic        s4_reg [18], s4_next [18];
    logic [47:0] tm5_reg [18], tm5_next [18];
    logic        ts5_reg [18], ts5_next [18];
    logic [63:0] norm5_reg, norm5_next;
    logic [47:0] bm6_reg [6], bm6_next [6];
    logic [63:0] norm6_reg, norm6_next;
    logic [47:0] pp7_reg [6][4], pp7_next [6][4];
    logic [63:0] norm7_reg, norm7_next;
    logic [95:0] pr8_reg [6], pr8_next [6];
    logic [63:0] norm8_reg, norm8_next;
    logic [97:0] pos9_reg, pos9_next, neg9_reg, neg9_next;
    logic [63:0] norm9_reg, norm9_next;
    logic        s10_added, s10_ovf;
    logic [97:0] s10_diff;

    logic [63:0] dv_rem_reg [0:DIV_STEPS], dv_rem_next [0:DIV_STEPS];
    logic [63:0] dv_q_reg [0:DIV_STEPS], dv_q_next [0:DIV_STEPS];
    logic [63:0] dv_den_reg [0:DIV_STEPS], dv_den_next [0:DIV_STEPS];
    logic [31:0] dv_low_reg [0:DIV_STEPS], dv_low_next [0:DIV_STEPS];
    logic [63:0] ratio;

    logic [63:0] sr_v_reg [1:SQRT_STEPS], sr_v_next [1:SQRT_STEPS];
    logic [33:0] sr_rem_reg [1:SQRT_STEPS], sr_rem_next [1:SQRT_STEPS];
    logic [31:0] sr_root_reg [1:SQRT_STEPS], sr_root_next [1:SQRT_STEPS];

    logic [63:0] t1_reg, t1_next;
    logic [58:0] t2_lo_reg, t2_lo_next, t2_hi_reg, t2_hi_next;
    logic [31:0] out_visc_reg, out_visc_next;
    logic        out_flag_reg, out_flag_next;
    logic        out_vld_reg;

    // configuration writes, taken every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                inv_reg[k] <= INV_SPACING_RST;
                sqs_reg[k] <= 32'd0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_INV_X:  inv_reg[0] <= cfg_data;
                REG_INV_Y:  inv_reg[1] <= cfg_data;
                REG_INV_Z:  inv_reg[2] <= cfg_data;
                REG_SQ_X:   sqs_reg[0] <= cfg_data;
                REG_SQ_Y:   sqs_reg[1] <= cfg_data;
                REG_SQ_Z:   sqs_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: move when the output register is free or being taken
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = advance;

    // valid bits and side data travelling with each beat
    always_comb begin
        vld_next = {vld_reg[PIPE_STAGES-1:1], s_tvalid};
        side_next[1] = '{dens: s_tdata[319:288], visc: s_tdata[351:320],
                         added: 1'b0, ovf: 1'b0};
        for (int n = 2; n <= PIPE_STAGES; n++) begin
            side_next[n] = side_reg[n-1];
        end
        side_next[FRONT_STAGES].added = s10_added;
        side_next[FRONT_STAGES].ovf   = s10_ovf;
    end

    // stage 1: magnitude of difference times reciprocal spacing
    always_comb begin
        logic [31:0] d;
        logic [31:0] dmag;
        for (int f = 0; f < NUM_DIFFS; f++) begin
            d          = s_tdata[32*f +: 32];
            dmag       = d[31] ? (~d + 32'd1) : d;
            m1_next[f] = 64'(dmag) * 64'(inv_reg[f % 3]);
            n1_next[f] = d[31];
        end
    end

    // stage 2: floor towards minus infinity and saturate the gradient
    always_comb begin
        logic [63:0] q;
        for (int f = 0; f < NUM_DIFFS; f++) begin
            if (n1_reg[f]) begin
                q = (m1_reg[f] + 64'd4095) >> 12;
                gm2_next[f] = (q > 64'h80000000) ? 32'h80000000 : q[31:0];
            end else begin
                q = m1_reg[f] >> 12;
                gm2_next[f] = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            end
            gs2_next[f] = n1_reg[f];
        end
    end

    // stage 3: squares and cross products of gradients
    always_comb begin
        int ia;
        int ja;
        for (int f = 0; f < NUM_DIFFS; f++) begin
            sq3_next[f] = 64'(gm2_reg[f]) * 64'(gm2_reg[f]);
        end
        for (int p = 0; p < 3; p++) begin
            ia = (p == 2) ? 1 : 0;
            ja = (p == 0) ? 1 : 2;
            for (int k = 0; k < 3; k++) begin
                om3_next[3*p+k] = 64'(gm2_reg[3*ia+k]) * 64'(gm2_reg[3*ja+k]);
                os3_next[3*p+k] = gs2_reg[3*ia+k] ^ gs2_reg[3*ja+k];
            end
        end
    end

    // stage 4: norm partial sums; products scaled by squared spacing in halves
    always_comb begin
        logic [63:0] mag;
        for (int i = 0; i < 3; i++) begin
            np4_next[i] = 66'(sq3_reg[3*i]) + 66'(sq3_reg[3*i+1]) + 66'(sq3_reg[3*i+2]);
        end
        for (int e = 0; e < 18; e++) begin
            mag         = (e < 9) ? sq3_reg[e % 9] : om3_reg[e % 9];
            s4_next[e]  = (e < 9) ? 1'b0 : os3_reg[e % 9];
            pl4_next[e] = 64'(mag[31:0]) * 64'(sqs_reg[e % 3]);
            ph4_next[e] = 64'(mag[63:32]) * 64'(sqs_reg[e % 3]);
        end
    end

    // stage 5: truncate beta terms; saturate and clamp the norm
    always_comb begin
        logic [95:0] p96;
        logic [67:0] ns;
        logic [63:0] nsat;
        for (int e = 0; e < 18; e++) begin
            p96         = {ph4_reg[e], 32'd0} + {32'd0, pl4_reg[e]};
            tm5_next[e] = p96[95:48];
            ts5_next[e] = s4_reg[e];
        end
        ns         = 68'(np4_reg[0]) + 68'(np4_reg[1]) + 68'(np4_reg[2]);
        nsat       = (ns[67:64] != 4'd0) ? {64{1'b1}} : ns[63:0];
        norm5_next = (nsat < 64'(NORM_MIN)) ? 64'(NORM_MIN) : nsat;
    end

    // stage 6: beta tensor entries as magnitudes
    always_comb begin
        logic signed [49:0] acc;
        logic signed [49:0] term;
        logic [49:0]        dsum;
        for (int i = 0; i < 3; i++) begin
            dsum = 50'(tm5_reg[3*i]) + 50'(tm5_reg[3*i+1]) + 50'(tm5_reg[3*i+2]);
            bm6_next[i] = dsum[47:0];
        end
        for (int p = 0; p < 3; p++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
                term = $signed({2'b00, tm5_reg[9+3*p+k]});
                acc  = ts5_reg[9+3*p+k] ? (acc - term) : (acc + term);
            end
            dsum = acc[49] ? 50'(-acc) : 50'(acc);
            bm6_next[3+p] = dsum[47:0];
        end
        norm6_next = norm5_reg;
    end

    // stage 7: partial products of the invariant, 24-bit halves
    always_comb begin
        int ai;
        int bi;
        for (int q = 0; q < 6; q++) begin
            ai = (q == 2) ? 1 : ((q < 2) ? 0 : q);
            bi = (q == 0) ? 1 : ((q < 3) ? 2 : q);
            pp7_next[q][0] = 48'(bm6_reg[ai][23:0]) * 48'(bm6_reg[bi][23:0]);
            pp7_next[q][1] = 48'(bm6_reg[ai][23:0]) * 48'(bm6_reg[bi][47:24]);
            pp7_next[q][2] = 48'(bm6_reg[ai][47:24]) * 48'(bm6_reg[bi][23:0]);
            pp7_next[q][3] = 48'(bm6_reg[ai][47:24]) * 48'(bm6_reg[bi][47:24]);
        end
        norm7_next = norm6_reg;
    end

    // stage 8: combine partial products
    always_comb begin
        for (int q = 0; q < 6; q++) begin
            pr8_next[q] = 96'(pp7_reg[q][0]) + (96'(pp7_reg[q][1]) << 24)
                        + (96'(pp7_reg[q][2]) << 24) + (96'(pp7_reg[q][3]) << 48);
        end
        norm8_next = norm7_reg;
    end

    // stage 9: positive and negative halves of the invariant
    always_comb begin
        pos9_next  = 98'(pr8_reg[0]) + 98'(pr8_reg[1]) + 98'(pr8_reg[2]);
        neg9_next  = 98'(pr8_reg[3]) + 98'(pr8_reg[4]) + 98'(pr8_reg[5]);
        norm9_next = norm8_reg;
    end

    // stage 10: threshold test and quotient overflow check
    always_comb begin
        s10_diff  = pos9_reg - neg9_reg;
        s10_added = enable_reg && (pos9_reg > neg9_reg) && (s10_diff > BB_THRESHOLD);
        s10_ovf   = s10_diff >= {2'b00, norm9_reg, 32'd0};
    end

    // restoring divider: load from stage 10, then one quotient bit per stage
    always_comb begin
        logic [64:0] t65;
        dv_rem_next[0] = s10_diff[95:32];
        dv_low_next[0] = s10_diff[31:0];
        dv_q_next[0]   = 64'd0;
        dv_den_next[0] = norm9_reg;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            t65 = {dv_rem_reg[s-1], dv_low_reg[s-1][31]};
            if (t65 >= {1'b0, dv_den_reg[s-1]}) begin
                t65            = t65 - {1'b0, dv_den_reg[s-1]};
                dv_q_next[s]   = {dv_q_reg[s-1][62:0], 1'b1};
            end else begin
                dv_q_next[s]   = {dv_q_reg[s-1][62:0], 1'b0};
            end
            dv_rem_next[s] = t65[63:0];
            dv_low_next[s] = {dv_low_reg[s-1][30:0], 1'b0};
            dv_den_next[s] = dv_den_reg[s-1];
        end
    end

    assign ratio = side_reg[SIDE_DIV].ovf ? {64{1'b1}} : dv_q_reg[DIV_STEPS];

    // digit-by-digit square root, one root bit per stage
    always_comb begin
        logic [63:0] vin;
        logic [33:0] remin;
        logic [31:0] rootin;
        logic [35:0] r36;
        logic [35:0] trial;
        for (int j = 1; j <= SQRT_STEPS; j++) begin
            vin    = (j == 1) ? ratio : sr_v_reg[(j == 1) ? 1 : j-1];
            remin  = (j == 1) ? 34'd0 : sr_rem_reg[(j == 1) ? 1 : j-1];
            rootin = (j == 1) ? 32'd0 : sr_root_reg[(j == 1) ? 1 : j-1];
            r36    = {remin, vin[63:62]};
            trial  = {2'b00, rootin, 2'b01};
            if (r36 >= trial) begin
                r36             = r36 - trial;
                sr_root_next[j] = {rootin[30:0], 1'b1};
            end else begin
                sr_root_next[j] = {rootin[30:0], 1'b0};
            end
            sr_rem_next[j] = r36[33:0];
            sr_v_next[j]   = {vin[61:0], 2'b00};
        end
    end

    // tail: density times root, times coefficient in halves, then add and saturate if flagged
    always_comb begin
        logic [91:0] m92;
        logic [39:0] term;
        logic [40:0] sum41;
        t1_next    = 64'(side_reg[SIDE_SQRT].dens) * 64'(sr_root_reg[SQRT_STEPS]);
        t2_lo_next = 59'(t1_reg[31:0]) * 59'(EDDY_COEF);
        t2_hi_next = 59'(t1_reg[63:32]) * 59'(EDDY_COEF);
        m92   = {1'b0, t2_hi_reg, 32'd0} + {33'd0, t2_lo_reg};
        term  = m92[91:52];
        sum41 = 41'(side_reg[PIPE_STAGES].visc) + 41'(term);
        if (side_reg[PIPE_STAGES].added) begin
            out_visc_next = (sum41 > 41'(VISC_CAP)) ? VISC_CAP[31:0] : sum41[31:0];
        end else begin
            out_visc_next = side_reg[PIPE_STAGES].visc;
        end
        out_flag_next = side_reg[PIPE_STAGES].added;
    end

    // payload registers: advance together, hold on stall
    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg     <= side_next;
            m1_reg       <= m1_next;
            n1_reg       <= n1_next;
            gm2_reg      <= gm2_next;
            gs2_reg      <= gs2_next;
            sq3_reg      <= sq3_next;
            om3_reg      <= om3_next;
            os3_reg      <= os3_next;
            np4_reg      <= np4_next;
            pl4_reg      <= pl4_next;
            ph4_reg      <= ph4_next;
            s4_reg       <= s4_next;
            tm5_reg      <= tm5_next;
            ts5_reg      <= ts5_next;
            norm5_reg    <= norm5_next;
            bm6_reg      <= bm6_next;
            norm6_reg    <= norm6_next;
            pp7_reg      <= pp7_next;
            norm7_reg    <= norm7_next;
            pr8_reg      <= pr8_next;
            norm8_reg    <= norm8_next;
            pos9_reg     <= pos9_next;
            neg9_reg     <= neg9_next;
            norm9_reg    <= norm9_next;
            dv_rem_reg   <= dv_rem_next;
            dv_q_reg     <= dv_q_next;
            dv_den_reg   <= dv_den_next;
            dv_low_reg   <= dv_low_next;
            sr_v_reg     <= sr_v_next;
            sr_rem_reg   <= sr_rem_next;
            sr_root_reg  <= sr_root_next;
            t1_reg       <= t1_next;
            t2_lo_reg    <= t2_lo_next;
            t2_hi_reg    <= t2_hi_next;
            out_visc_reg <= out_visc_next;
            out_flag_reg <= out_flag_next;
        end
    end

    // valid bits: cleared on reset, shift on advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[PIPE_STAGES];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_visc_reg;
    assign m_tuser  = out_flag_reg;

    // checks on pipeline control and the iterative units
    `VEE_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[1], "accepted beat lost at entry")
    `VEE_ASSERT_NEXT(a_stall_holds, !advance, vld_reg == $past(vld_reg), "pipeline moved during stall")
    `VEE_ASSERT_IMP(a_div_rem, vld_reg[SIDE_DIV] && !side_reg[SIDE_DIV].ovf, dv_rem_reg[DIV_STEPS] < dv_den_reg[DIV_STEPS], "divider remainder not below divisor")
    `VEE_ASSERT_IMP(a_sqrt_rem, vld_reg[SIDE_SQRT], sr_rem_reg[SQRT_STEPS] <= {1'b0, sr_root_reg[SQRT_STEPS], 1'b0}, "square root remainder out of bound")

endmodule
